// ===== sv/tsp_pkg.sv =====
// Package: types, stage map and helper functions of the trapezoid speed planner.
package tsp_pkg;

    localparam int POS_BITS   = 24;
    localparam int SPD_BITS   = 24;
    localparam int FRAC_BITS  = 8;
    localparam int VMAX_BITS  = 16;
    localparam int ACC_BITS   = 20;
    localparam int RATIO_FRAC = 16;

    localparam logic [SPD_BITS-1:0] PRIME_FLOOR = SPD_BITS'(50 << FRAC_BITS);
    // floor(y / 5) = (y * VMIN_MUL) >> VMIN_SHIFT for y below 2**22
    localparam logic [22:0] VMIN_MUL   = 23'd6710887;
    localparam int          VMIN_SHIFT = 25;

    localparam int DIV_BITS = 32;
    localparam int SQ_STEPS = 24;
    localparam int RAT_BITS = RATIO_FRAC;

    localparam int ST_DOM       = 1;
    localparam int ST_MUL       = 2;
    localparam int ST_DIV_FIRST = 3;
    localparam int ST_DIV_LAST  = ST_DIV_FIRST + DIV_BITS - 1;
    localparam int ST_BOUND     = ST_DIV_LAST + 1;
    localparam int ST_SEL       = ST_BOUND + 1;
    localparam int ST_RAD       = ST_SEL + 1;
    localparam int ST_SQ_LOAD   = ST_RAD + 1;
    localparam int ST_SQ_FIRST  = ST_SQ_LOAD + 1;
    localparam int ST_SQ_LAST   = ST_SQ_FIRST + SQ_STEPS - 1;
    localparam int ST_TGT       = ST_SQ_LAST + 1;
    localparam int ST_RAT_FIRST = ST_TGT + 1;
    localparam int ST_RAT_LAST  = ST_RAT_FIRST + RAT_BITS - 1;
    localparam int ST_RATIO     = ST_RAT_LAST + 1;
    localparam int ST_OUT       = ST_RATIO + 1;
    localparam int NUM_STAGES   = ST_OUT;

    typedef enum logic [1:0] {
        PH_ACCEL  = 2'd0,
        PH_CRUISE = 2'd1,
        PH_DECEL  = 2'd2,
        PH_PRIME  = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        REG_MAX_X = 3'd0,
        REG_MAX_Y = 3'd1,
        REG_MAX_Z = 3'd2,
        REG_ACC_X = 3'd3,
        REG_ACC_Y = 3'd4,
        REG_ACC_Z = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [2:0][VMAX_BITS-1:0] vmax;
        logic [2:0][ACC_BITS-1:0]  acc;
    } t_cfg;

    typedef struct packed {
        logic                       func;
        logic                       nothing;
        logic [2:0]                 load;
        logic [2:0]                 eq;
        logic [VMAX_BITS-1:0]       v;
        logic [ACC_BITS-1:0]        a;
        logic [POS_BITS-1:0]        d;
        logic [POS_BITS-1:0]        p;
        logic [SPD_BITS-1:0]        vtop;
        logic [SPD_BITS-1:0]        vmin;
        logic [31:0]                vv;
        logic [43:0]                da;
        logic                       triangle;
        logic [DIV_BITS-1:0]        dn;
        logic [ACC_BITS:0]          drem;
        logic [POS_BITS-1:0]        start;
        logic [POS_BITS-1:0]        stop;
        t_phase                     phase;
        logic [POS_BITS-1:0]        n;
        logic [44:0]                rad;
        logic                       big;
        logic [47:0]                sx;
        logic [25:0]                srem;
        logic [SPD_BITS-1:0]        sroot;
        logic [SPD_BITS-1:0]        target;
        logic                       rsat;
        logic [SPD_BITS-1:0]        rrem;
        logic [RAT_BITS-1:0]        rq;
        logic [RATIO_FRAC:0]        ratio;
        logic [2:0][SPD_BITS-1:0]   spd;
    } t_item;

    function automatic t_item div_step(t_item t);
        logic [ACC_BITS+1:0] cur;
        logic [ACC_BITS+1:0] dvs;
        cur = {t.drem, t.dn[DIV_BITS-1]};
        dvs = {1'b0, t.a, 1'b0};
        if (cur >= dvs) begin
            t.drem = (ACC_BITS+1)'(cur - dvs);
            t.dn   = {t.dn[DIV_BITS-2:0], 1'b1};
        end else begin
            t.drem = (ACC_BITS+1)'(cur);
            t.dn   = {t.dn[DIV_BITS-2:0], 1'b0};
        end
        return t;
    endfunction

    function automatic t_item sqrt_step(t_item t);
        logic [27:0] cur;
        logic [27:0] trial;
        cur   = {t.srem, t.sx[47:46]};
        trial = {2'b00, t.sroot, 2'b01};
        if (cur >= trial) begin
            t.srem  = 26'(cur - trial);
            t.sroot = {t.sroot[SPD_BITS-2:0], 1'b1};
        end else begin
            t.srem  = 26'(cur);
            t.sroot = {t.sroot[SPD_BITS-2:0], 1'b0};
        end
        t.sx = {t.sx[45:0], 2'b00};
        return t;
    endfunction

    function automatic t_item ratio_step(t_item t);
        logic [SPD_BITS:0] cur;
        cur = {t.rrem, 1'b0};
        if (cur >= {1'b0, t.vtop}) begin
            t.rrem = SPD_BITS'(cur - {1'b0, t.vtop});
            t.rq   = {t.rq[RAT_BITS-2:0], 1'b1};
        end else begin
            t.rrem = SPD_BITS'(cur);
            t.rq   = {t.rq[RAT_BITS-2:0], 1'b0};
        end
        return t;
    endfunction

endpackage

// ===== sv/tsp_cfg_regs.sv =====
// Configuration register file of the trapezoid speed planner, APB-style access.
module tsp_cfg_regs
    import tsp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[4:2]);
    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.vmax[0] <= VMAX_BITS'(4000);
            r_cfg.vmax[1] <= VMAX_BITS'(4000);
            r_cfg.vmax[2] <= VMAX_BITS'(1000);
            r_cfg.acc[0]  <= ACC_BITS'(40000);
            r_cfg.acc[1]  <= ACC_BITS'(40000);
            r_cfg.acc[2]  <= ACC_BITS'(10000);
        end else if (w_wr) begin
            case (w_idx)
                REG_MAX_X: if (pwdata[15:0] != '0) r_cfg.vmax[0] <= pwdata[15:0];
                REG_MAX_Y: if (pwdata[15:0] != '0) r_cfg.vmax[1] <= pwdata[15:0];
                REG_MAX_Z: if (pwdata[15:0] != '0) r_cfg.vmax[2] <= pwdata[15:0];
                REG_ACC_X: if (pwdata[19:0] != '0) r_cfg.acc[0]  <= pwdata[19:0];
                REG_ACC_Y: if (pwdata[19:0] != '0) r_cfg.acc[1]  <= pwdata[19:0];
                REG_ACC_Z: if (pwdata[19:0] != '0) r_cfg.acc[2]  <= pwdata[19:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_MAX_X: prdata = 32'(r_cfg.vmax[0]);
            REG_MAX_Y: prdata = 32'(r_cfg.vmax[1]);
            REG_MAX_Z: prdata = 32'(r_cfg.vmax[2]);
            REG_ACC_X: prdata = 32'(r_cfg.acc[0]);
            REG_ACC_Y: prdata = 32'(r_cfg.acc[1]);
            REG_ACC_Z: prdata = 32'(r_cfg.acc[2]);
            default:   prdata = '0;
        endcase
    end

endmodule

// ===== sv/trapezoid_speed_planner.sv =====
// Top level of the three-axis trapezoidal speed planner pipeline.
//
//   channel   direction  handshake           payload
//   s_*       in         s_tvalid/s_tready   tdata: travel and progress, tuser: func
//   m_*       out        m_tvalid/m_tready   tdata: speeds, loads, phase, nothing_to_move
//   apb       in         psel/penable        register writes and reads
//
// One item enters per cycle while the output is not stalled; an item passes through 81 register
// stages to the output register, a number set by the 32-step bound divider, the 24-step square
// root and the 16-step ratio divider, one step per stage.
// Reset clears all valid bits and restores register defaults.
// A stall at the output freezes the whole pipeline; s_tready follows it.
module trapezoid_speed_planner
    import tsp_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // dist_x, dist_y, dist_z, done_x, done_y, done_z
    input  logic [143:0] s_tdata,
    // func
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // speed_x, speed_y, speed_z, load_x, load_y, load_z, phase, nothing_to_move, 2 pad
    output logic [79:0]  m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    t_cfg  w_cfg;
    t_item r_pipe [1:NUM_STAGES];
    t_item n_pipe [1:NUM_STAGES];
    logic [NUM_STAGES:1] r_vld;
    logic  w_adv;

    tsp_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign w_adv    = ~r_vld[NUM_STAGES] | m_tready;
    assign s_tready = w_adv;
    assign m_tvalid = r_vld[NUM_STAGES];
    assign m_tdata  = {2'b00, r_pipe[NUM_STAGES].nothing, r_pipe[NUM_STAGES].phase,
                       r_pipe[NUM_STAGES].load, r_pipe[NUM_STAGES].spd[2],
                       r_pipe[NUM_STAGES].spd[1], r_pipe[NUM_STAGES].spd[0]};

    always_comb begin
        t_item t;
        logic [2:0][POS_BITS-1:0] trav;
        logic [2:0][POS_BITS-1:0] done;
        logic [POS_BITS-1:0]      pm;
        logic [45:0]              vprod;
        logic [DIV_BITS-1:0]      ceilq;
        logic [SPD_BITS-1:0]      s;
        logic [40:0]              sc;

        vprod = '0;
        ceilq = '0;
        s     = '0;
        sc    = '0;
        for (int i = 0; i < 3; i++) begin
            trav[i] = s_tdata[i*POS_BITS +: POS_BITS];
            done[i] = s_tdata[(i+3)*POS_BITS +: POS_BITS];
        end
        t = r_pipe[1];
        t.func    = s_tuser[0];
        t.nothing = (trav[0] == '0) && (trav[1] == '0) && (trav[2] == '0);
        if (trav[0] >= trav[1] && trav[0] >= trav[2]) begin
            t.v = w_cfg.vmax[0]; t.a = w_cfg.acc[0]; t.d = trav[0];
        end else if (trav[1] >= trav[2]) begin
            t.v = w_cfg.vmax[1]; t.a = w_cfg.acc[1]; t.d = trav[1];
        end else begin
            t.v = w_cfg.vmax[2]; t.a = w_cfg.acc[2]; t.d = trav[2];
        end
        for (int i = 0; i < 3; i++) begin
            t.load[i] = trav[i] != '0;
            t.eq[i]   = trav[i] == t.d;
        end
        pm = done[0];
        if (done[1] > pm) pm = done[1];
        if (done[2] > pm) pm = done[2];
        t.p    = pm;
        t.vtop = {t.v, FRAC_BITS'(0)};
        n_pipe[ST_DOM] = t;

        for (int k = 2; k <= NUM_STAGES; k++) begin
            t = r_pipe[k-1];
            if (k == ST_MUL) begin
                t.vv   = 32'(t.v) * 32'(t.v);
                t.da   = 44'(t.d) * 44'(t.a);
                vprod  = 46'(t.vtop[SPD_BITS-1:2]) * 46'(VMIN_MUL);
                t.vmin = SPD_BITS'(vprod >> VMIN_SHIFT);
                t.dn   = t.vv;
                t.drem = '0;
            end
            if (k == ST_DIV_FIRST) begin
                t.triangle = 44'(t.vv) > t.da;
            end
            if (k >= ST_DIV_FIRST && k <= ST_DIV_LAST) begin
                t = div_step(t);
            end
            if (k == ST_BOUND) begin
                ceilq = t.dn + DIV_BITS'(t.drem != '0);
                if (t.triangle) begin
                    t.start = t.d >> 1;
                    t.stop  = t.d >> 1;
                end else begin
                    t.start = t.dn[POS_BITS-1:0];
                    t.stop  = t.d - ceilq[POS_BITS-1:0];
                end
            end
            if (k == ST_SEL) begin
                if (t.p < t.start) begin
                    t.phase = PH_ACCEL;
                    t.n     = (t.p == '0) ? POS_BITS'(1) : t.p;
                end else if (t.p < t.stop) begin
                    t.phase = PH_CRUISE;
                    t.n     = t.p;
                end else begin
                    t.phase = PH_DECEL;
                    t.n     = (t.p < t.d) ? t.d - t.p : POS_BITS'(1);
                end
                if (!t.func) t.phase = PH_PRIME;
            end
            if (k == ST_RAD) begin
                t.rad = 45'({t.a, 1'b0}) * 45'(t.n);
            end
            if (k == ST_SQ_LOAD) begin
                t.big   = t.rad >= 45'(t.vv);
                t.sx    = {t.rad[31:0], 16'b0};
                t.srem  = '0;
                t.sroot = '0;
            end
            if (k >= ST_SQ_FIRST && k <= ST_SQ_LAST) begin
                t = sqrt_step(t);
            end
            if (k == ST_TGT) begin
                s = t.sroot;
                if (s > t.vtop) s = t.vtop;
                if (s < t.vmin) s = t.vmin;
                case (t.phase)
                    PH_PRIME:  t.target = (t.vmin > PRIME_FLOOR) ? t.vmin : PRIME_FLOOR;
                    PH_CRUISE: t.target = t.vtop;
                    default:   t.target = t.big ? t.vtop : s;
                endcase
                t.rsat = t.target >= t.vtop;
                t.rrem = t.target;
                t.rq   = '0;
            end
            if (k >= ST_RAT_FIRST && k <= ST_RAT_LAST) begin
                t = ratio_step(t);
            end
            if (k == ST_RATIO) begin
                t.ratio = t.rsat ? (RATIO_FRAC+1)'(1 << RATIO_FRAC)
                                 : (RATIO_FRAC+1)'(t.rq);
            end
            if (k == ST_OUT) begin
                for (int i = 0; i < 3; i++) begin
                    sc = 41'({w_cfg.vmax[i], FRAC_BITS'(0)}) * 41'(t.ratio);
                    if (!t.load[i]) begin
                        t.spd[i] = '0;
                    end else if (t.eq[i]) begin
                        t.spd[i] = t.target;
                    end else if (sc[40] != 1'b0) begin
                        t.spd[i] = '1;
                    end else begin
                        t.spd[i] = sc[39:16];
                    end
                end
                if (t.nothing) t.phase = PH_ACCEL;
            end
            n_pipe[k] = t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[NUM_STAGES-1:1], s_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int k = 1; k <= NUM_STAGES; k++) begin
                r_pipe[k] <= n_pipe[k];
            end
        end
    end

endmodule
